// File: hw/rtl/bdcm_pkg.sv
// Shared types, constants and constant functions of the band-to-disk map.
package bdcm_pkg;

    localparam int CORDIC_STEPS_DEF = 20;
    localparam int TBL = 32;

    // Internal CORDIC word width (Q2.30 with headroom).
    localparam int CW = 36;

    // Divider: 7 integer and 16 fraction quotient bits.
    localparam int FRAC_BITS = 16;
    localparam int DIV_BITS  = 23;
    localparam int INT_BITS  = DIV_BITS - FRAC_BITS;
    localparam int DW        = 52;
    localparam int MW        = 51;
    localparam int RW        = MW + 1;
    localparam int EW        = 50;

    localparam longint unsigned LN2_Q30        = 64'd744261118;
    localparam longint unsigned HALF_LN2_Q30   = 64'd372130559;
    localparam longint unsigned NUMK_OFS       = 20 * LN2_Q30 + HALF_LN2_Q30;
    localparam longint unsigned PI_Q30         = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;
    localparam longint unsigned TWO_PI_Q30     = 64'd6746518852;
    localparam longint unsigned QUARTER_PI_Q30 = 64'd843314857;
    localparam longint unsigned NUMM_OFS       = 64 * TWO_PI_Q30;
    localparam longint unsigned SAT_Q30        = 64'd12884901888;
    localparam int K_BIAS = 20;

    // Reciprocals of the Q30 values of ln2 and 2*pi, scaled by 2^44 and 2^48.
    localparam int RECIP_LN2    = 23637;
    localparam int RECIP_TWO_PI = 41721;

    localparam logic signed [23:0] DISK_MIN   = 24'sh800000;
    localparam logic signed [23:0] DISK_ONE   = 24'sd65536;
    localparam logic signed [23:0] DISK_MAX   = 24'sd8388607;
    localparam logic signed [15:0] MARK_COUNT = -16'sd1000;

    typedef struct packed {
        logic signed [23:0] x_coord;
        logic signed [23:0] y_coord;
        logic signed [15:0] inversion_count;
    } t_pix_in;

    typedef struct packed {
        logic signed [23:0] disk_x;
        logic signed [23:0] disk_y;
        logic signed [15:0] inversion_out;
    } t_disk_out;

    // Control that travels alongside each word through the pipeline.
    typedef struct packed {
        logic              vld;
        logic              special;
        t_disk_out         spec;
        logic              flip;
        logic signed [5:0] k;
        logic              pole;
        logic              neg_x;
        logic              neg_y;
        logic              nz_x;
        logic              nz_y;
    } t_side;

    // Shift-subtract division, used only to build constants.
    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned v;
        res  = 0;
        bitv = 64'd1 << 62;
        v    = n;
        for (int i = 0; i < 32; i++) begin
            if (bitv > v) bitv = bitv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // Arctangent (alternating) or inverse hyperbolic tangent series of 2^-s.
    function automatic longint unsigned series_q30(int s, bit alt);
        longint unsigned sum;
        longint unsigned term;
        int e;
        sum = 0;
        for (int k = 0; k < 64; k++) begin
            e = 62 - s * (2 * k + 1);
            if (e >= 0) begin
                term = udiv64(64'd1 << e, 64'(2 * k + 1));
                if (alt && k[0]) sum = sum - term;
                else sum = sum + term;
            end
        end
        return (sum + (64'd1 << 31)) >> 32;
    endfunction

    function automatic longint unsigned atan_q30(int j);
        return (j == 0) ? QUARTER_PI_Q30 : series_q30(j, 1'b1);
    endfunction

    function automatic longint unsigned atanh_q30(int j);
        return (j == 0) ? 64'd0 : series_q30(j, 1'b0);
    endfunction

    // Hyperbolic shift sequence; shifts 4 and 13 are repeated.
    function automatic int hyp_shift(int j);
        int s;
        int rep;
        int res;
        bit done;
        s    = 1;
        rep  = 4;
        done = 1'b0;
        res  = 1;
        for (int t = 0; t < TBL; t++) begin
            if (t == j) res = s;
            if (s == rep && !done) begin
                done = 1'b1;
            end else begin
                if (s == rep) rep = 3 * rep + 1;
                done = 1'b0;
                s++;
            end
        end
        return res;
    endfunction

    function automatic longint unsigned circ_x0(int steps);
        longint unsigned g;
        g = 64'd1 << 30;
        for (int j = 0; j < TBL; j++) begin
            if (j < steps && 2 * j <= 60)
                g = (g * isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * j)))) >> 30;
        end
        return udiv64((64'd1 << 60) + (g >> 1), g);
    endfunction

    function automatic longint unsigned hyp_x0(int steps);
        longint unsigned g;
        int sh;
        g = 64'd1 << 30;
        for (int j = 0; j < TBL; j++) begin
            sh = hyp_shift(j);
            if (j < steps && sh >= 1 && sh <= 30)
                g = (g * isqrt64((64'd1 << 60) - (64'd1 << (60 - 2 * sh)))) >> 30;
        end
        return udiv64((64'd1 << 60) + (g >> 1), g);
    endfunction

endpackage

// File: hw/rtl/band_to_disk_conformal_map_top.sv
// Top level of the band-to-disk conformal map pipeline.
//
// Input channel i_valid / o_stall carries one pixel word (band x, y in Q8.16
// and an inversion count); output channel o_valid / i_stall returns one disk
// word per pixel, in order. A word moves when valid is high and stall is low.
// The pipeline takes one pixel every cycle while o_stall is low. It has six
// range reduction stages, one stage per CORDIC iteration, four exponent and
// denominator stages, 24 divider stages and the output register.
// When the output register holds a word and the receiver stalls, the whole
// pipeline freezes and o_stall rises; nothing is dropped or repeated, and
// bubbles in the pipeline are kept.
// i_cfg_wr_en writes the mark-invalid bit (1 after reset); change it only
// while the pipeline is empty. Reset empties the pipeline at once.
// Pixels with a negative count come out marked or unchanged; pixels with
// |x*pi/2| >= 12 come out as +-1.0.
module band_to_disk_conformal_map_top
    import bdcm_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_pix_in   i_pix,
    output logic      o_valid,
    input  logic      i_stall,
    output t_disk_out o_disk
);

    localparam logic signed [38:0] SAT_A      = 39'(SAT_Q30);
    localparam logic signed [CW-1:0] PI_C     = CW'(PI_Q30);
    localparam logic signed [CW-1:0] HPI_C    = CW'(HALF_PI_Q30);
    localparam logic signed [CW-1:0] TWO_PI_C = CW'(TWO_PI_Q30);

    logic en;
    logic r_mark;

    // Stage 1: scale by pi/2.
    logic                r_s1_vld;
    t_pix_in             r_s1_pix;
    logic signed [38:0]  r_s1_a, r_s1_b;
    logic signed [55:0]  n_prod_a, n_prod_b;

    // Stage 2: offsets for the quotient estimates, special cases.
    t_side               r_s2_side, n_s2_side;
    logic signed [39:0]  r_s2_numk;
    logic [39:0]         r_s2_numm;
    logic                n_invalid, n_sat;

    // Stage 3: quotient estimates.
    t_side               r_s3_side;
    logic [39:0]         r_s3_numk;
    logic [39:0]         r_s3_numm;
    logic [5:0]          r_s3_qk;
    logic [7:0]          r_s3_qm;
    logic [29:0]         n_pk;
    logic [31:0]         n_pm;

    // Stage 4: remainders.
    t_side               r_s4_side;
    logic [5:0]          r_s4_qk;
    logic [31:0]         r_s4_remk;
    logic [35:0]         r_s4_remm;
    logic [35:0]         n_lk;
    logic [40:0]         n_lm;

    // Stage 5: one correction step.
    t_side               r_s5_side, n_s5_side;
    logic signed [CW-1:0] r_s5_r;
    logic [35:0]         r_s5_m;
    logic [5:0]          n_qk1;
    logic [31:0]         n_remk1;
    logic [35:0]         n_m;

    // Stage 6: fold the angle into [-pi/2, pi/2].
    t_side               r_s6_side, n_s6_side;
    logic signed [CW-1:0] r_s6_cz, r_s6_hz, n_fold;

    // CORDIC outputs.
    t_side               c_side;
    logic signed [CW-1:0] c_cx, c_cy, c_hx, c_hy;

    // Post stages.
    t_side               r_p1_side, r_p2_side, r_p3_side, r_p4_side, n_p4_side;
    logic signed [CW:0]  n_ep, n_em;
    logic [31:0]         r_p1_ep, r_p1_em;
    logic signed [CW-1:0] r_p1_cx, r_p1_cy, r_p2_cx, r_p2_cy;
    logic [4:0]          n_amt;
    logic [EW-1:0]       r_p2_e, r_p2_ei, n_e, n_ei;
    logic signed [DW-1:0] r_p3_den, r_p3_nx, r_p3_ny;
    logic [1:0][MW-1:0]  r_p4_mag;
    logic [MW-1:0]       r_p4_den;

    // Divider outputs.
    t_side                    d_side;
    logic [1:0]               d_ovf;
    logic [1:0][DIV_BITS-1:0] d_q;

    logic      r_out_vld;
    t_disk_out r_out, n_out;

    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_out_vld;
    assign o_disk  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_mark <= i_cfg_wr_data;
        end
    end

    // ---------------- Stage 1 ----------------
    assign n_prod_a = i_pix.x_coord * $signed(32'sd1686629713);
    assign n_prod_b = i_pix.y_coord * $signed(32'sd1686629713);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
            r_s1_pix <= i_pix;
            r_s1_a   <= n_prod_a[54:16];
            r_s1_b   <= n_prod_b[54:16];
        end
    end

    // ---------------- Stage 2 ----------------
    always_comb begin
        n_invalid = r_s1_pix.inversion_count[15];
        n_sat     = (r_s1_a >= SAT_A) || (r_s1_a <= -SAT_A);
        n_s2_side = '0;
        n_s2_side.vld     = r_s1_vld;
        n_s2_side.special = n_invalid || n_sat;
        n_s2_side.spec.inversion_out = r_s1_pix.inversion_count;
        if (n_invalid) begin
            if (r_mark) begin
                n_s2_side.spec.disk_x        = DISK_MIN;
                n_s2_side.spec.disk_y        = DISK_MIN;
                n_s2_side.spec.inversion_out = MARK_COUNT;
            end else begin
                n_s2_side.spec.disk_x = r_s1_pix.x_coord;
                n_s2_side.spec.disk_y = r_s1_pix.y_coord;
            end
        end else if (n_sat) begin
            n_s2_side.spec.disk_x = (r_s1_pix.x_coord > 0) ? DISK_ONE : -DISK_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_side.vld <= 1'b0;
        end else if (en) begin
            r_s2_side <= n_s2_side;
            r_s2_numk <= 40'(r_s1_a) + 40'(NUMK_OFS);
            r_s2_numm <= 40'(41'(r_s1_b) + 41'(NUMM_OFS));
        end
    end

    // ---------------- Stage 3 ----------------
    assign n_pk = r_s2_numk[34:20] * 15'(RECIP_LN2);
    assign n_pm = r_s2_numm[39:24] * 16'(RECIP_TWO_PI);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_side.vld <= 1'b0;
        end else if (en) begin
            r_s3_side <= r_s2_side;
            r_s3_numk <= r_s2_numk;
            r_s3_numm <= r_s2_numm;
            r_s3_qk   <= n_pk[29:24];
            r_s3_qm   <= n_pm[31:24];
        end
    end

    // ---------------- Stage 4 ----------------
    assign n_lk = r_s3_qk * 30'(LN2_Q30);
    assign n_lm = r_s3_qm * 33'(TWO_PI_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_side.vld <= 1'b0;
        end else if (en) begin
            r_s4_side <= r_s3_side;
            r_s4_qk   <= r_s3_qk;
            r_s4_remk <= 32'(36'(r_s3_numk[34:0]) - n_lk);
            r_s4_remm <= 36'(41'(r_s3_numm) - n_lm);
        end
    end

    // ---------------- Stage 5 ----------------
    // The estimates are at most one low, so one compare and subtract finishes.
    always_comb begin
        n_qk1   = r_s4_qk;
        n_remk1 = r_s4_remk;
        if (r_s4_remk >= 32'(LN2_Q30)) begin
            n_qk1   = r_s4_qk + 6'd1;
            n_remk1 = r_s4_remk - 32'(LN2_Q30);
        end
        n_m = r_s4_remm;
        if (r_s4_remm >= 36'(TWO_PI_Q30)) n_m = r_s4_remm - 36'(TWO_PI_Q30);
        n_s5_side   = r_s4_side;
        n_s5_side.k = $signed(n_qk1 - 6'(K_BIAS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_side.vld <= 1'b0;
        end else if (en) begin
            r_s5_side <= n_s5_side;
            r_s5_r    <= $signed(CW'(n_remk1) - CW'(HALF_LN2_Q30));
            r_s5_m    <= n_m;
        end
    end

    // ---------------- Stage 6 ----------------
    always_comb begin
        n_s6_side = r_s5_side;
        n_fold    = $signed(r_s5_m);
        if (n_fold >= PI_C) n_fold = n_fold - TWO_PI_C;
        if (n_fold > HPI_C) begin
            n_fold = n_fold - PI_C;
            n_s6_side.flip = 1'b1;
        end else if (n_fold < -HPI_C) begin
            n_fold = n_fold + PI_C;
            n_s6_side.flip = 1'b1;
        end else begin
            n_s6_side.flip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_side.vld <= 1'b0;
        end else if (en) begin
            r_s6_side <= n_s6_side;
            r_s6_cz   <= n_fold;
            r_s6_hz   <= r_s5_r;
        end
    end

    bdcm_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (r_s6_side),
        .i_cz    (r_s6_cz),
        .i_hz    (r_s6_hz),
        .o_side  (c_side),
        .o_cx    (c_cx),
        .o_cy    (c_cy),
        .o_hx    (c_hx),
        .o_hy    (c_hy)
    );

    // ---------------- P1: e^r and e^-r, quadrant flip ----------------
    assign n_ep = (CW+1)'(c_hx) + (CW+1)'(c_hy);
    assign n_em = (CW+1)'(c_hx) - (CW+1)'(c_hy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_side.vld <= 1'b0;
        end else if (en) begin
            r_p1_side <= c_side;
            r_p1_ep   <= n_ep[CW] ? 32'd0 : n_ep[31:0];
            r_p1_em   <= n_em[CW] ? 32'd0 : n_em[31:0];
            r_p1_cx   <= c_side.flip ? -c_cx : c_cx;
            r_p1_cy   <= c_side.flip ? -c_cy : c_cy;
        end
    end

    // ---------------- P2: scale by 2^k and 2^-k ----------------
    always_comb begin
        if (r_p1_side.k[5]) begin
            n_amt = 5'(-r_p1_side.k);
            n_e   = EW'(r_p1_ep) >> n_amt;
            n_ei  = EW'(r_p1_em) << n_amt;
        end else begin
            n_amt = 5'(r_p1_side.k);
            n_e   = EW'(r_p1_ep) << n_amt;
            n_ei  = EW'(r_p1_em) >> n_amt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_side.vld <= 1'b0;
        end else if (en) begin
            r_p2_side <= r_p1_side;
            r_p2_e    <= n_e;
            r_p2_ei   <= n_ei;
            r_p2_cx   <= r_p1_cx;
            r_p2_cy   <= r_p1_cy;
        end
    end

    // ---------------- P3: denominator and numerators ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_side.vld <= 1'b0;
        end else if (en) begin
            r_p3_side <= r_p2_side;
            r_p3_den  <= $signed(DW'(r_p2_e)) + $signed(DW'(r_p2_ei))
                         + (DW'(r_p2_cx) <<< 1);
            r_p3_nx   <= $signed(DW'(r_p2_e)) - $signed(DW'(r_p2_ei));
            r_p3_ny   <= DW'(r_p2_cy) <<< 1;
        end
    end

    // ---------------- P4: magnitudes, signs, pole ----------------
    always_comb begin
        n_p4_side       = r_p3_side;
        n_p4_side.pole  = r_p3_den[DW-1] || (r_p3_den == '0);
        n_p4_side.neg_x = r_p3_nx[DW-1];
        n_p4_side.neg_y = r_p3_ny[DW-1];
        n_p4_side.nz_x  = (r_p3_nx != '0);
        n_p4_side.nz_y  = (r_p3_ny != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_side.vld <= 1'b0;
        end else if (en) begin
            r_p4_side   <= n_p4_side;
            r_p4_mag[0] <= MW'(r_p3_nx[DW-1] ? -r_p3_nx : r_p3_nx);
            r_p4_mag[1] <= MW'(r_p3_ny[DW-1] ? -r_p3_ny : r_p3_ny);
            r_p4_den    <= r_p3_den[MW-1:0];
        end
    end

    bdcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (r_p4_side),
        .i_mag   (r_p4_mag),
        .i_den   (r_p4_den),
        .o_side  (d_side),
        .o_ovf   (d_ovf),
        .o_q     (d_q)
    );

    // ---------------- Output register ----------------
    function automatic logic signed [23:0] lane_out(
        logic pole, logic ovf, logic neg, logic nz, logic [DIV_BITS-1:0] q
    );
        logic signed [23:0] mag;
        if (pole) mag = nz ? DISK_MAX : 24'sd0;
        else if (ovf) mag = DISK_MAX;
        else mag = $signed({1'b0, q});
        return neg ? -mag : mag;
    endfunction

    always_comb begin
        if (d_side.special) begin
            n_out = d_side.spec;
        end else begin
            n_out.disk_x = lane_out(d_side.pole, d_ovf[0], d_side.neg_x, d_side.nz_x, d_q[0]);
            n_out.disk_y = lane_out(d_side.pole, d_ovf[1], d_side.neg_y, d_side.nz_y, d_q[1]);
            n_out.inversion_out = d_side.spec.inversion_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_side.vld;
            r_out     <= n_out;
        end
    end

    // ---------------- Assertions ----------------
    a_reset_empty : assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_cfg_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_mark == $past(i_cfg_wr_data)))
        else $error("mark-invalid register not written");

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_vld)
        else $error("accepted word did not enter the pipeline");

    a_freeze : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(r_s1_vld) && $stable(r_p4_side.vld)))
        else $error("pipeline moved while output stalled");

endmodule

// File: hw/rtl/bdcm_cordic.sv
// Pipelined circular and hyperbolic CORDIC, one iteration per stage.
module bdcm_cordic
    import bdcm_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_side                i_side,
    input  logic signed [CW-1:0] i_cz,
    input  logic signed [CW-1:0] i_hz,
    output t_side                o_side,
    output logic signed [CW-1:0] o_cx,
    output logic signed [CW-1:0] o_cy,
    output logic signed [CW-1:0] o_hx,
    output logic signed [CW-1:0] o_hy
);

    localparam logic signed [CW-1:0] CX0 = CW'(circ_x0(STEPS));
    localparam logic signed [CW-1:0] HX0 = CW'(hyp_x0(STEPS));

    t_side                r_side [1:STEPS];
    logic signed [CW-1:0] r_cx   [1:STEPS];
    logic signed [CW-1:0] r_cy   [1:STEPS];
    logic signed [CW-1:0] r_cz   [1:STEPS];
    logic signed [CW-1:0] r_hx   [1:STEPS];
    logic signed [CW-1:0] r_hy   [1:STEPS];
    logic signed [CW-1:0] r_hz   [1:STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        localparam int SH = hyp_shift(g);
        localparam logic signed [CW-1:0] ATAN_C  = CW'(atan_q30(g));
        localparam logic signed [CW-1:0] ATANH_C = CW'(atanh_q30(SH));

        t_side                s_side;
        logic signed [CW-1:0] s_cx, s_cy, s_cz, s_hx, s_hy, s_hz;

        if (g == 0) begin : g_first
            assign s_side = i_side;
            assign s_cx   = CX0;
            assign s_cy   = '0;
            assign s_cz   = i_cz;
            assign s_hx   = HX0;
            assign s_hy   = '0;
            assign s_hz   = i_hz;
        end else begin : g_next
            assign s_side = r_side[g];
            assign s_cx   = r_cx[g];
            assign s_cy   = r_cy[g];
            assign s_cz   = r_cz[g];
            assign s_hx   = r_hx[g];
            assign s_hy   = r_hy[g];
            assign s_hz   = r_hz[g];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[g+1].vld <= 1'b0;
            end else if (i_en) begin
                r_side[g+1] <= s_side;
                if (s_cz >= 0) begin
                    r_cx[g+1] <= s_cx - (s_cy >>> g);
                    r_cy[g+1] <= s_cy + (s_cx >>> g);
                    r_cz[g+1] <= s_cz - ATAN_C;
                end else begin
                    r_cx[g+1] <= s_cx + (s_cy >>> g);
                    r_cy[g+1] <= s_cy - (s_cx >>> g);
                    r_cz[g+1] <= s_cz + ATAN_C;
                end
                if (s_hz >= 0) begin
                    r_hx[g+1] <= s_hx + (s_hy >>> SH);
                    r_hy[g+1] <= s_hy + (s_hx >>> SH);
                    r_hz[g+1] <= s_hz - ATANH_C;
                end else begin
                    r_hx[g+1] <= s_hx - (s_hy >>> SH);
                    r_hy[g+1] <= s_hy - (s_hx >>> SH);
                    r_hz[g+1] <= s_hz + ATANH_C;
                end
            end
        end
    end

    assign o_side = r_side[STEPS];
    assign o_cx   = r_cx[STEPS];
    assign o_cy   = r_cy[STEPS];
    assign o_hx   = r_hx[STEPS];
    assign o_hy   = r_hy[STEPS];

endmodule

// File: hw/rtl/bdcm_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
module bdcm_div
    import bdcm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_side                    i_side,
    input  logic [1:0][MW-1:0]       i_mag,
    input  logic [MW-1:0]            i_den,
    output t_side                    o_side,
    output logic [1:0]               o_ovf,
    output logic [1:0][DIV_BITS-1:0] o_q
);

    t_side                     r_side [0:DIV_BITS];
    logic [1:0]                r_ovf  [0:DIV_BITS];
    logic [MW-1:0]             r_d    [0:DIV_BITS];
    logic [1:0][RW-1:0]        r_rem  [0:DIV_BITS];
    logic [1:0][INT_BITS-1:0]  r_low  [0:DIV_BITS];
    logic [1:0][DIV_BITS-1:0]  r_q    [0:DIV_BITS];

    // Entry stage: overflow check and the integer part of the dividend.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0].vld <= 1'b0;
        end else if (i_en) begin
            r_side[0] <= i_side;
            r_d[0]    <= i_den;
            for (int l = 0; l < 2; l++) begin
                r_ovf[0][l] <= (i_mag[l] >> INT_BITS) >= i_den;
                r_rem[0][l] <= RW'(i_mag[l] >> INT_BITS);
                r_low[0][l] <= i_mag[l][INT_BITS-1:0];
                r_q[0][l]   <= '0;
            end
        end
    end

    for (genvar s = 0; s < DIV_BITS; s++) begin : g_stage
        localparam int B = DIV_BITS - 1 - s;
        logic [1:0] s_nbit;
        logic [1:0][RW-1:0] s_t;

        for (genvar l = 0; l < 2; l++) begin : g_lane
            if (B >= FRAC_BITS) begin : g_int
                assign s_nbit[l] = r_low[s][l][B-FRAC_BITS];
            end else begin : g_frac
                assign s_nbit[l] = 1'b0;
            end
            assign s_t[l] = {r_rem[s][l][RW-2:0], s_nbit[l]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s+1].vld <= 1'b0;
            end else if (i_en) begin
                r_side[s+1] <= r_side[s];
                r_ovf[s+1]  <= r_ovf[s];
                r_d[s+1]    <= r_d[s];
                r_low[s+1]  <= r_low[s];
                for (int l = 0; l < 2; l++) begin
                    if (s_t[l] >= RW'(r_d[s])) begin
                        r_rem[s+1][l]  <= s_t[l] - RW'(r_d[s]);
                        r_q[s+1][l]    <= r_q[s][l] | (DIV_BITS'(1) << B);
                    end else begin
                        r_rem[s+1][l]  <= s_t[l];
                        r_q[s+1][l]    <= r_q[s][l];
                    end
                end
            end
        end
    end

    assign o_side = r_side[DIV_BITS];
    assign o_ovf  = r_ovf[DIV_BITS];
    assign o_q    = r_q[DIV_BITS];

endmodule
